// ===== rtl/lphd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash dictionary package
// Shared constants, codes and the control/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lphd_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int unsigned TABLE_DEPTH_DEF     = 1024;
  localparam int unsigned MAX_KEY_WORDS_DEF   = 4;
  localparam int unsigned MAX_VALUE_WORDS_DEF = 4;

  // Fixed field geometry of the stream items.
  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned IN_DATA_W  = 520;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 264;
  localparam int unsigned OUT_USER_W = 3;

  // Slot count after reset.
  localparam logic [CFG_W-1:0] SLOTS_RESET = 11'd1024;

  // FNV-1a constants. The prime is 2^40 + 0x1b3.
  localparam logic [WORD_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam int unsigned       FNV_SHIFT = 40;
  localparam logic [8:0]        FNV_LOW   = 9'h1b3;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } command_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_OVERFLOW  = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    hash_step;
    logic    div_step;
    logic    probe_init;
    logic    rd;
    logic    probe_next;
    logic    wr;
    logic    res_set;
    status_e res_code;
    logic    resp_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic     clr_last;
    logic     hash_last;
    logic     div_last;
    command_e cmd;
    logic     full_pre;
    logic     row_used;
    logic     row_match;
    logic     value_ovf;
    logic     probe_last;
    logic     out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/lphd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash dictionary controller
// Sequences table clearing, hashing, the modulo reduction, the probe walk,
// the table write and the result hand-off.
// ----------------------------------------------------------------------------
module lphd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lphd_pkg::ctrl_sts_t sts_i,
  output lphd_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_START = 9'b000010000,
    S_READ  = 9'b000100000,
    S_CHECK = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          state_d = S_START;
        end
        cmd_o.div_step = 1'b1;
      end
      S_START: begin
        if (sts_i.cmd == lphd_pkg::CMD_NONE) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = lphd_pkg::STAT_NOT_FOUND;
          state_d        = S_RESP;
        end else if (sts_i.cmd != lphd_pkg::CMD_LOOKUP && sts_i.full_pre) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = lphd_pkg::STAT_FULL;
          state_d        = S_RESP;
        end else begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.res_set = 1'b1;
        if (sts_i.cmd == lphd_pkg::CMD_LOOKUP) begin
          if (!sts_i.row_used) begin
            cmd_o.res_code = lphd_pkg::STAT_NOT_FOUND;
            state_d        = S_RESP;
          end else if (sts_i.row_match) begin
            cmd_o.res_code = lphd_pkg::STAT_FOUND;
            state_d        = S_RESP;
          end else if (sts_i.probe_last) begin
            cmd_o.res_code = lphd_pkg::STAT_NOT_FOUND;
            state_d        = S_RESP;
          end else begin
            cmd_o.res_set    = 1'b0;
            cmd_o.probe_next = 1'b1;
            state_d          = S_READ;
          end
        end else begin
          if (!sts_i.row_used || sts_i.row_match) begin
            if (sts_i.value_ovf) begin
              cmd_o.res_code = lphd_pkg::STAT_OVERFLOW;
              state_d        = S_RESP;
            end else begin
              cmd_o.res_code = sts_i.row_used ? lphd_pkg::STAT_UPDATED
                                              : lphd_pkg::STAT_INSERTED;
              state_d        = S_WRITE;
            end
          end else if (sts_i.probe_last) begin
            cmd_o.res_code = lphd_pkg::STAT_FULL;
            state_d        = S_RESP;
          end else begin
            cmd_o.res_set    = 1'b0;
            cmd_o.probe_next = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; the table is swept clear after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // The hash and divide phases always precede the walk.
  a_walk_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START && state_d == S_READ) |=> (state_q == S_READ))
    else $error("walk did not start after dispatch");
  a_write_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> ($past(state_q) == S_CHECK))
    else $error("table write not preceded by a probe check");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

endmodule

// ===== rtl/lphd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash dictionary datapath
// Request registers, byte-serial FNV-1a hash, radix-16 remainder unit, the
// slot table memory, probe counters and the result register.
// ----------------------------------------------------------------------------
module lphd_datapath #(
  parameter int unsigned TABLE_DEPTH     = lphd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_KEY_WORDS   = lphd_pkg::MAX_KEY_WORDS_DEF,
  parameter int unsigned MAX_VALUE_WORDS = lphd_pkg::MAX_VALUE_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lphd_pkg::ctrl_cmd_t                 cmd_i,
  output lphd_pkg::ctrl_sts_t                 sts_o,
  input  logic [lphd_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [lphd_pkg::IN_USER_W-1:0]      in_user_i,
  input  logic                                cfg_valid_i,
  input  logic [lphd_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lphd_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [lphd_pkg::OUT_USER_W-1:0]     out_user_o
);

  localparam int unsigned NW      = lphd_pkg::NUM_WORDS;
  localparam int unsigned WW      = lphd_pkg::WORD_W;
  localparam int unsigned LW      = lphd_pkg::LEN_W;
  localparam int unsigned CW      = lphd_pkg::CFG_W;
  localparam int unsigned IW      = $clog2(TABLE_DEPTH);
  localparam int unsigned XW      = ((IW > CW) ? IW : CW) + 1;
  localparam int unsigned KEY_CAP = (MAX_KEY_WORDS < NW) ? MAX_KEY_WORDS : NW;
  localparam int unsigned VAL_CAP = (MAX_VALUE_WORDS < NW) ? MAX_VALUE_WORDS : NW;
  localparam int unsigned DEPTH_CLIP = (TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH;
  localparam int unsigned KOFF    = LW;
  localparam int unsigned VLOFF   = LW + NW * WW;
  localparam int unsigned VOFF    = 2 * LW + NW * WW;
  localparam int unsigned PAD_W   = lphd_pkg::OUT_DATA_W - LW - NW * WW;

  // Configuration register and effective modulus.
  logic [CW-1:0] slots_q;
  logic [CW-1:0] mod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= lphd_pkg::SLOTS_RESET;
    end else if (cfg_valid_i) begin
      slots_q <= cfg_data_i;
    end
  end

  always_comb begin
    mod = slots_q;
    if (slots_q == '0) begin
      mod = CW'(1);
    end else if (slots_q > CW'(DEPTH_CLIP)) begin
      mod = CW'(DEPTH_CLIP);
    end
  end

  // Request registers.
  lphd_pkg::command_e      cmd_q;
  logic [LW-1:0]           klen_q;
  logic [LW-1:0]           vlen_q;
  logic [NW-1:0][WW-1:0]   key_q;
  logic [NW-1:0][WW-1:0]   val_q;
  logic [LW-1:0]           klen_in;

  always_comb begin
    klen_in = in_data_i[LW-1:0];
    if (klen_in == '0) begin
      klen_in = LW'(1);
    end else if (klen_in > LW'(KEY_CAP)) begin
      klen_in = LW'(KEY_CAP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= lphd_pkg::command_e'(in_user_i);
      klen_q <= klen_in;
      key_q  <= in_data_i[KOFF +: NW*WW];
      vlen_q <= in_data_i[VLOFF +: LW];
      val_q  <= in_data_i[VOFF +: NW*WW];
    end
  end

  // Byte-serial FNV-1a: xor one byte, then multiply by 2^40 + 0x1b3.
  logic [WW-1:0] hash_q, hash_d;
  logic [4:0]    bcnt_q;
  logic [WW-1:0] hx;
  logic [72:0]   hprod;
  logic [7:0]    hbyte;
  logic [4:0]    last_byte;

  always_comb begin
    hbyte     = key_q[bcnt_q[4:3]][8*bcnt_q[2:0] +: 8];
    hx        = hash_q ^ {56'b0, hbyte};
    hprod     = hx * lphd_pkg::FNV_LOW;
    hash_d    = (hx << lphd_pkg::FNV_SHIFT) + hprod[WW-1:0];
    last_byte = 5'({klen_q - LW'(1), 3'b111});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hash_q <= lphd_pkg::FNV_BASIS;
      bcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hash_q <= hash_d;
      bcnt_q <= bcnt_q + 5'd1;
    end
  end

  // Remainder unit: four restoring steps per cycle over the 64-bit hash.
  logic [WW-1:0] div_q;
  logic [CW-1:0] rem_q, rem_d;
  logic [3:0]    dcnt_q;
  logic [CW:0]   racc;

  always_comb begin
    racc = {1'b0, rem_q};
    for (int k = 0; k < 4; k++) begin
      racc = {racc[CW-1:0], div_q[WW-1-k]};
      if (racc >= {1'b0, mod}) begin
        racc = racc - {1'b0, mod};
      end
    end
    rem_d = racc[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_step && bcnt_q == last_byte) begin
      div_q  <= hash_d;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q  <= div_q << 4;
      rem_q  <= rem_d;
      dcnt_q <= dcnt_q + 4'd1;
    end
  end

  // Probe position, probe count and table bookkeeping.
  logic [IW-1:0] idx_q;
  logic [IW-1:0] clr_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] occ_q;
  logic [CW-1:0] longest_q;
  logic [CW:0]   n_inc;
  logic [CW-1:0] lim;
  logic [IW-1:0] idx_next;

  // Registered read row of the slot table.
  logic                       row_used_q;
  logic [LW-1:0]              row_klen_q;
  logic [KEY_CAP-1:0][WW-1:0] row_key_q;
  logic [LW-1:0]              row_vlen_q;
  logic [VAL_CAP-1:0][WW-1:0] row_val_q;

  assign n_inc = {1'b0, n_q} + (CW+1)'(1);
  assign lim   = (longest_q < mod) ? longest_q : mod;

  always_comb begin
    if (XW'(idx_q) + XW'(1) == XW'(mod)) begin
      idx_next = '0;
    end else begin
      idx_next = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_init) begin
      idx_q <= IW'(rem_q);
      n_q   <= '0;
    end else if (cmd_i.probe_next) begin
      idx_q <= idx_next;
      n_q   <= n_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      occ_q     <= '0;
      longest_q <= CW'(1);
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + IW'(1);
      end
      if (cmd_i.wr && !row_used_q) begin
        occ_q <= occ_q + CW'(1);
        if (n_inc > {1'b0, longest_q}) begin
          longest_q <= n_inc[CW-1:0];
        end
      end
    end
  end

  // Slot table memory.
  logic                       mem_used [TABLE_DEPTH];
  logic [LW-1:0]              mem_klen [TABLE_DEPTH];
  logic [KEY_CAP-1:0][WW-1:0] mem_key  [TABLE_DEPTH];
  logic [LW-1:0]              mem_vlen [TABLE_DEPTH];
  logic [VAL_CAP-1:0][WW-1:0] mem_val  [TABLE_DEPTH];

  logic [KEY_CAP-1:0][WW-1:0] wr_key;
  logic [VAL_CAP-1:0][WW-1:0] wr_val;
  logic [LW-1:0]              wr_vlen;
  logic [LW-1:0]              base;
  logic [LW:0]                vsum;
  logic                       row_match;

  // Append starts after the stored words; insert overwrites from word zero.
  assign base = (cmd_q == lphd_pkg::CMD_APPEND) ? row_vlen_q : '0;
  assign vsum = {1'b0, base} + {1'b0, vlen_q};

  always_comb begin
    for (int w = 0; w < KEY_CAP; w++) begin
      wr_key[w] = key_q[w];
    end
    for (int j = 0; j < VAL_CAP; j++) begin
      if (!row_used_q) begin
        wr_val[j] = val_q[j];
      end else if ((LW+1)'(j) >= {1'b0, base} && (LW+1)'(j) < vsum) begin
        wr_val[j] = val_q[2'((LW+1)'(j) - {1'b0, base})];
      end else begin
        wr_val[j] = row_val_q[j];
      end
    end
    wr_vlen = row_used_q ? vsum[LW-1:0] : vlen_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_used[clr_q] <= 1'b0;
    end else if (cmd_i.wr) begin
      mem_used[idx_q] <= 1'b1;
      mem_klen[idx_q] <= klen_q;
      mem_key[idx_q]  <= wr_key;
      mem_vlen[idx_q] <= wr_vlen;
      mem_val[idx_q]  <= wr_val;
    end
    if (cmd_i.rd) begin
      row_used_q <= mem_used[idx_q];
      row_klen_q <= mem_klen[idx_q];
      row_key_q  <= mem_key[idx_q];
      row_vlen_q <= mem_vlen[idx_q];
      row_val_q  <= mem_val[idx_q];
    end
  end

  // Key compare over the valid words only.
  always_comb begin
    row_match = (row_klen_q == klen_q);
    for (int w = 0; w < KEY_CAP; w++) begin
      if (LW'(w) < klen_q && row_key_q[w] != key_q[w]) begin
        row_match = 1'b0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.clr_last   = (clr_q == IW'(TABLE_DEPTH - 1));
    sts_o.hash_last  = (bcnt_q == last_byte);
    sts_o.div_last   = (dcnt_q == 4'd15);
    sts_o.cmd        = cmd_q;
    sts_o.full_pre   = (occ_q >= mod);
    sts_o.row_used   = row_used_q;
    sts_o.row_match  = row_match;
    sts_o.value_ovf  = row_used_q ? (vsum > (LW+1)'(VAL_CAP))
                                  : (vlen_q > LW'(VAL_CAP));
    sts_o.probe_last = (cmd_q == lphd_pkg::CMD_LOOKUP) ? (n_inc >= {1'b0, lim})
                                                       : (n_inc >= {1'b0, mod});
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

  // Result code register.
  lphd_pkg::status_e res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_q <= cmd_i.res_code;
    end
  end

  // Output register; found words past the stored length read as zero.
  logic [NW-1:0][WW-1:0] found_words;
  logic                  hit;

  assign hit = (res_q == lphd_pkg::STAT_FOUND);

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      found_words[w] = '0;
    end
    for (int w = 0; w < VAL_CAP; w++) begin
      if (hit && LW'(w) < row_vlen_q) begin
        found_words[w] = row_val_q[w];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_user_o <= res_q;
      out_data_o <= {PAD_W'(0), found_words, hit ? row_vlen_q : LW'(0)};
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH_CLIP))
    else $error("occupied count above table depth");
  a_longest_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    longest_q != '0)
    else $error("longest probe distance is zero");
  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr && !row_used_q) |=> (occ_q == $past(occ_q) + CW'(1)))
    else $error("new key did not raise the occupied count");
  a_resp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp_load |=> out_valid_o)
    else $error("result not presented after load");

endmodule

// ===== rtl/linear_probe_hash_dictionary_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash dictionary
// Open-addressing key/value store with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot table clear, one slot per cycle,
// before it takes its first request; configuration writes are taken at any
// time. Each request then passes through a load step, the byte-serial hash
// of the key words, the radix-16 remainder by the slot count, a dispatch
// step, a synchronous table read and then a compare for each probed slot,
// a write for a store, and the load of the result register, which waits
// until the result output is free. The hash unit and the probe walk over the
// single table port set the time that a request takes. One request is in
// work at a time; a new one is taken while the previous result waits.
// ----------------------------------------------------------------------------
module linear_probe_hash_dictionary_top #(
  parameter int unsigned TABLE_DEPTH     = lphd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_KEY_WORDS   = lphd_pkg::MAX_KEY_WORDS_DEF,
  parameter int unsigned MAX_VALUE_WORDS = lphd_pkg::MAX_VALUE_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_len[2:0], key_word_0..3 [258:3], value_len[261:259],
  // value_word_0..3 [517:262], zero pad [519:518]
  input  logic [lphd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [lphd_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // Slot count register.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lphd_pkg::CFG_W-1:0]      cfg_data_i,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // found_len[2:0], found_word_0..3 [258:3], zero pad [263:259]
  output logic [lphd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [lphd_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  lphd_pkg::ctrl_cmd_t ctrl_cmd;
  lphd_pkg::ctrl_sts_t ctrl_sts;

  assign cfg_ready_o = 1'b1;

  lphd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  lphd_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_KEY_WORDS   (MAX_KEY_WORDS),
    .MAX_VALUE_WORDS (MAX_VALUE_WORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
